[sv/voig_pkg.sv]
`default_nettype none

package voig_pkg;

   localparam int DEF_MAX_FACTORS = 16;
   localparam int DEF_MAX_STEPS   = 64;

   // field widths of the item on the response channel
   localparam int FACTOR_IDX_W = 4;
   localparam int STEP_IDX_W   = 6;
   localparam int VARIATE_W    = 10;

   // configuration register widths
   localparam int NUM_FACTORS_W = 5;
   localparam int NUM_STEPS_W   = 7;
   localparam int ORDER_W       = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 7;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_FACTORS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_STEPS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WALK_ORDER  = 2'd2;

   localparam logic [ORDER_W-1:0] ORDER_STEP = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_DIAG = 2'd2;

   typedef struct packed {
      logic [NUM_FACTORS_W-1:0] num_factors;
      logic [NUM_STEPS_W-1:0]   num_steps;
      logic [ORDER_W-1:0]       walk_order;
   } voig_cfg_type;

   typedef struct packed {
      logic [FACTOR_IDX_W-1:0] factor_index;
      logic [STEP_IDX_W-1:0]   step_index;
      logic [VARIATE_W-1:0]    variate_number;
      logic                    last_of_walk;
   } voig_cell_type;

endpackage

`default_nettype wire

[sv/voig_req_if.sv]
`default_nettype none

interface voig_req_if ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

[sv/voig_rsp_if.sv]
`default_nettype none

interface voig_rsp_if import voig_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FACTOR_IDX_W-1:0] factor_index;
   logic [STEP_IDX_W-1:0]   step_index;
   logic [VARIATE_W-1:0]    variate_number;
   logic                    last_of_walk;

   modport source (output valid, output factor_index, output step_index,
                   output variate_number, output last_of_walk, input ready);
   modport sink (input valid, input factor_index, input step_index,
                 input variate_number, input last_of_walk, output ready);
endinterface

`default_nettype wire

[sv/voig_walk.sv]
`default_nettype none

module voig_walk import voig_pkg::*; #(
   parameter int MAX_FACTORS = DEF_MAX_FACTORS,
   parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire voig_cfg_type  cfg,
   input  wire logic          advance,
   input  wire logic          restart,
   output voig_cell_type      pos
);

   localparam int FW   = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
   localparam int SW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CW   = (MAX_FACTORS * MAX_STEPS > 1) ? $clog2(MAX_FACTORS * MAX_STEPS) : 1;
   localparam int NFW  = $clog2(MAX_FACTORS + 1);
   localparam int NSW  = $clog2(MAX_STEPS + 1);
   localparam int PW   = NFW + NSW;
   // one spare bit: a position may step one past the table after an order change
   localparam int FSW  = FW + 1;
   localparam int SSW  = SW + 1;

   logic [NFW-1:0] nf_c;
   logic [NSW-1:0] ns_c;
   logic [PW-1:0]  cells_c;

   logic [FW-1:0]  nf_m1_ff, nf_m1_in;
   logic [SW-1:0]  ns_m1_ff, ns_m1_in;
   logic [CW-1:0]  cells_m1_ff, cells_m1_in;
   logic [ORDER_W-1:0] order_ff, order_in;

   logic [FSW-1:0] cf_ff, cf_in, dsf_ff, dsf_in;
   logic [SSW-1:0] cs_ff, cs_in, dss_ff, dss_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   logic           fresh;
   logic           last;
   logic [FSW-1:0] eff_cf, eff_dsf, nf_m1_x;
   logic [SSW-1:0] eff_cs, eff_dss, ns_m1_x;
   logic [CW-1:0]  eff_cnt;

   // clamped table size, registered once so the item path sees no multiplier
   always_comb begin
      if (cfg.num_factors == '0) begin
         nf_c = NFW'(1);
      end else if (int'(cfg.num_factors) > MAX_FACTORS) begin
         nf_c = NFW'(MAX_FACTORS);
      end else begin
         nf_c = NFW'(cfg.num_factors);
      end
      if (cfg.num_steps == '0) begin
         ns_c = NSW'(1);
      end else if (int'(cfg.num_steps) > MAX_STEPS) begin
         ns_c = NSW'(MAX_STEPS);
      end else begin
         ns_c = NSW'(cfg.num_steps);
      end
      cells_c     = PW'(nf_c) * PW'(ns_c);
      nf_m1_in    = FW'(nf_c - 1'b1);
      ns_m1_in    = SW'(ns_c - 1'b1);
      cells_m1_in = CW'(cells_c - 1'b1);
      order_in    = cfg.walk_order;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_m1_ff    <= '0;
         ns_m1_ff    <= '0;
         cells_m1_ff <= '0;
         order_ff    <= '0;
      end else begin
         nf_m1_ff    <= nf_m1_in;
         ns_m1_ff    <= ns_m1_in;
         cells_m1_ff <= cells_m1_in;
         order_ff    <= order_in;
      end
   end

   always_comb begin
      nf_m1_x = FSW'(nf_m1_ff);
      ns_m1_x = SSW'(ns_m1_ff);
      fresh = restart || (cf_ff > nf_m1_x) || (cs_ff > ns_m1_x) ||
              (dsf_ff > nf_m1_x) || (dss_ff > ns_m1_x) || (cnt_ff > cells_m1_ff);
      if (fresh) begin
         eff_cf  = '0;
         eff_cs  = '0;
         eff_dsf = '0;
         eff_dss = '0;
         eff_cnt = '0;
      end else begin
         eff_cf  = cf_ff;
         eff_cs  = cs_ff;
         eff_dsf = dsf_ff;
         eff_dss = dss_ff;
         eff_cnt = cnt_ff;
      end
      last = (eff_cnt == cells_m1_ff);

      pos.factor_index   = FACTOR_IDX_W'(eff_cf);
      pos.step_index     = STEP_IDX_W'(eff_cs);
      pos.variate_number = VARIATE_W'(eff_cnt);
      pos.last_of_walk   = last;

      cf_in  = eff_cf;
      cs_in  = eff_cs;
      dsf_in = eff_dsf;
      dss_in = eff_dss;
      cnt_in = CW'(eff_cnt + 1'b1);
      case (order_ff)
         ORDER_STEP: begin
            if (eff_cf == nf_m1_x) begin
               cf_in = '0;
               cs_in = SSW'(eff_cs + 1'b1);
            end else begin
               cf_in = FSW'(eff_cf + 1'b1);
            end
         end
         ORDER_DIAG: begin
            if (eff_cf == '0 || eff_cs == ns_m1_x) begin
               // next anti-diagonal
               if (eff_dsf != nf_m1_x) begin
                  dsf_in = FSW'(eff_dsf + 1'b1);
                  dss_in = '0;
               end else begin
                  dsf_in = nf_m1_x;
                  dss_in = SSW'(eff_dss + 1'b1);
               end
               cf_in = dsf_in;
               cs_in = dss_in;
            end else begin
               cf_in = FSW'(eff_cf - 1'b1);
               cs_in = SSW'(eff_cs + 1'b1);
            end
         end
         default: begin
            if (eff_cs != ns_m1_x) begin
               cs_in = SSW'(eff_cs + 1'b1);
            end else begin
               cs_in = '0;
               cf_in = FSW'(eff_cf + 1'b1);
            end
         end
      endcase
      if (last) begin
         cf_in  = '0;
         cs_in  = '0;
         dsf_in = '0;
         dss_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff  <= '0;
         cs_ff  <= '0;
         dsf_ff <= '0;
         dss_ff <= '0;
         cnt_ff <= '0;
      end else if (advance) begin
         cf_ff  <= cf_in;
         cs_ff  <= cs_in;
         dsf_ff <= dsf_in;
         dss_ff <= dss_in;
         cnt_ff <= cnt_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && last |=> cnt_ff == '0 && cf_ff == '0 && cs_ff == '0)
      else $error("walk did not start over after the last cell");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      advance && restart |-> pos.variate_number == '0 && pos.factor_index == '0 &&
                             pos.step_index == '0)
      else $error("restart item not at the first cell");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !last |=> cnt_ff == CW'($past(eff_cnt) + 1'b1))
      else $error("variate count did not advance by one");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cnt_ff) && $stable(cf_ff) && $stable(cs_ff))
      else $error("walk state moved without an item");

endmodule

`default_nettype wire

[sv/variate_order_index_generator.sv]
`default_nettype none

// Variate order index generator. Each item on req_chan yields one item on
// rsp_chan: the (factor, step) cell of a num_factors x num_steps table that
// takes the next variate number, the number itself, and a flag on the last
// cell of the table; the item after it starts a new walk, as does restart.
// walk_order selects factor-major (0 or 3), step-major (1) or anti-diagonal
// (2) order. Throughput is one item per clock while rsp_chan takes results;
// an item passes the input register and then the result register, and the
// next-cell logic between them is the only path an item takes. Configuration writes on
// the csr_ port take effect for items accepted from the cycle after the write.
module variate_order_index_generator import voig_pkg::*; #(
   parameter int MAX_FACTORS = DEF_MAX_FACTORS,
   parameter int MAX_STEPS   = DEF_MAX_STEPS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   voig_req_if.sink                   req_chan,
   voig_rsp_if.source                 rsp_chan
);

   voig_cfg_type  cfg_ff, cfg_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_restart_ff, s1_restart_in;
   logic          out_valid_ff, out_valid_in;
   voig_cell_type out_cell_ff, out_cell_in;
   voig_cell_type walk_pos;
   logic          out_free;
   logic          s1_go;
   logic          req_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_NUM_FACTORS: cfg_in.num_factors = csr_wdata[NUM_FACTORS_W-1:0];
            REG_NUM_STEPS:   cfg_in.num_steps   = csr_wdata[NUM_STEPS_W-1:0];
            REG_WALK_ORDER:  cfg_in.walk_order  = csr_wdata[ORDER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_factors <= NUM_FACTORS_W'(1);
         cfg_ff.num_steps   <= NUM_STEPS_W'(1);
         cfg_ff.walk_order  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_restart_in = s1_restart_ff;
      if (req_fire) begin
         s1_valid_in   = 1'b1;
         s1_restart_in = req_chan.restart;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_cell_in  = out_cell_ff;
      if (s1_go) begin
         out_valid_in = 1'b1;
         out_cell_in  = walk_pos;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_restart_ff <= s1_restart_in;
      out_cell_ff   <= out_cell_in;
   end

   voig_walk #(
      .MAX_FACTORS (MAX_FACTORS),
      .MAX_STEPS   (MAX_STEPS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (s1_go),
      .restart (s1_restart_ff),
      .pos     (walk_pos)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.factor_index   = out_cell_ff.factor_index;
   assign rsp_chan.step_index     = out_cell_ff.step_index;
   assign rsp_chan.variate_number = out_cell_ff.variate_number;
   assign rsp_chan.last_of_walk   = out_cell_ff.last_of_walk;

endmodule

`default_nettype wire
